### sv/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types and constants of the text console glyph renderer: the request
// and response items, the configuration set, and controller/datapath signals.
// ----------------------------------------------------------------------------
package tcgr_pkg;

   localparam int CELL_WIDTH = 8;
   localparam int CSR_ADDR_W = 5;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] SPACE_CODE   = 8'd32;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_PUT  = 1'b1;

   localparam logic [1:0] DEPTH_16 = 2'd0;
   localparam logic [1:0] DEPTH_24 = 2'd1;

   localparam logic [2:0] REG_FB_BASE      = 3'd0;
   localparam logic [2:0] REG_LINE_PITCH   = 3'd1;
   localparam logic [2:0] REG_DEPTH_MODE   = 3'd2;
   localparam logic [2:0] REG_TEXT_COLUMNS = 3'd3;
   localparam logic [2:0] REG_TEXT_ROWS    = 3'd4;

   typedef struct packed {
      logic        op;
      logic [7:0]  char_code;
      logic [12:0] font_index;
      logic [7:0]  font_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] row_address;
      logic [7:0]  pixel_mask;
      logic        last_row;
   } rsp_type;

   typedef struct packed {
      logic [31:0] fb_base;
      logic [15:0] line_pitch;
      logic [1:0]  depth_mode;
      logic [9:0]  text_columns;
      logic [9:0]  text_rows;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic prep;
      logic rd_issue;
      logic rd_last;
   } cmd_type;

   typedef struct packed {
      logic glyph_req;
      logic q_free;
   } sts_type;

endpackage

### sv/tcgr_csr.sv
// ----------------------------------------------------------------------------
// tcgr_csr
// Configuration register file with an APB-style write/read port.
// ----------------------------------------------------------------------------
module tcgr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tcgr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   output tcgr_pkg::cfg_type                cfg
);
   import tcgr_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_index;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_FB_BASE:      cfg_in.fb_base      = csr_pwdata;
            REG_LINE_PITCH:   cfg_in.line_pitch   = csr_pwdata[15:0];
            REG_DEPTH_MODE:   cfg_in.depth_mode   = csr_pwdata[1:0];
            REG_TEXT_COLUMNS: cfg_in.text_columns = csr_pwdata[9:0];
            REG_TEXT_ROWS:    cfg_in.text_rows    = csr_pwdata[9:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_FB_BASE:      csr_prdata = cfg_ff.fb_base;
         REG_LINE_PITCH:   csr_prdata = {16'd0, cfg_ff.line_pitch};
         REG_DEPTH_MODE:   csr_prdata = {30'd0, cfg_ff.depth_mode};
         REG_TEXT_COLUMNS: csr_prdata = {22'd0, cfg_ff.text_columns};
         REG_TEXT_ROWS:    csr_prdata = {22'd0, cfg_ff.text_rows};
         default:          csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fb_base      <= 32'd0;
         cfg_ff.line_pitch   <= 16'd0;
         cfg_ff.depth_mode   <= DEPTH_24;
         cfg_ff.text_columns <= 10'd80;
         cfg_ff.text_rows    <= 10'd32;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/tcgr_ctrl.sv
// ----------------------------------------------------------------------------
// tcgr_ctrl
// Sequencer: takes items, then issues one font read per glyph row for each drawn glyph.
// ----------------------------------------------------------------------------
module tcgr_ctrl #(
   parameter int GLYPH_ROWS = 15
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tcgr_pkg::sts_type sts,
   output tcgr_pkg::cmd_type cmd
);
   import tcgr_pkg::*;

   localparam int ROW_W = $clog2(GLYPH_ROWS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PREP = 2'd1;
   localparam logic [1:0] ST_ROWS = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [ROW_W-1:0] row_ff, row_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && sts.glyph_req) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            row_in   = '0;
            state_in = ST_ROWS;
         end
         ST_ROWS: begin
            if (sts.q_free) begin
               cmd.rd_issue = 1'b1;
               cmd.rd_last  = (row_ff == ROW_W'(GLYPH_ROWS - 1));
               row_in       = row_ff + ROW_W'(1);
               if (cmd.rd_last) begin
                  row_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
      end
   end

endmodule

### sv/tcgr_dp.sv
// ----------------------------------------------------------------------------
// tcgr_dp
// Datapath: cursor, glyph store, row address and font index steppers, and the
// two-entry read/output pipeline toward the response channel.
// ----------------------------------------------------------------------------
module tcgr_dp #(
   parameter int FONT_IMAGE_WIDTH = 128,
   parameter int FONT_STORE_BYTES = 8192,
   parameter int GLYPH_ROWS       = 15
) (
   input  logic              clock,
   input  logic              reset,
   input  tcgr_pkg::cfg_type cfg,
   input  tcgr_pkg::req_type req_item,
   input  tcgr_pkg::cmd_type cmd,
   output tcgr_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tcgr_pkg::rsp_type rsp_item
);
   import tcgr_pkg::*;

   localparam int IMG_PITCH     = FONT_IMAGE_WIDTH / 8;
   localparam int GLYPH_SPAN    = FONT_IMAGE_WIDTH - CELL_WIDTH;
   localparam int FONT_ROW_STEP = (GLYPH_ROWS + 1) * IMG_PITCH;
   localparam int AW            = $clog2(FONT_STORE_BYTES);
   localparam int FIDX_W        = $clog2(256 * (GLYPH_ROWS + 1) * IMG_PITCH);
   localparam int LPX_W         = 10 + $clog2(GLYPH_ROWS + 1);

   logic [9:0]        col_ff, col_in, line_ff, line_in;
   logic [10:0]       col_inc, line_inc, line_nx;
   logic [7:0]        gq_tab, gx_tab;
   logic [7:0]        gq_ff, gx_ff;
   logic [LPX_W-1:0]  lpx_ff;
   logic [15:0]       xoff_ff;
   logic [2:0]        bpp;
   logic [FIDX_W-1:0] fidx_ff, fidx_in;
   logic [31:0]       addr_ff, addr_in;
   logic              code_put, fb_en, load_ok, rd_ok, move;

   logic [7:0]        glyph_mem [FONT_STORE_BYTES];
   logic [7:0]        mem_q_ff;
   logic              q_valid_ff, q_zero_ff, q_last_ff;
   logic [31:0]       q_addr_ff;
   logic              out_valid_ff;
   rsp_type           out_item_ff;

   assign code_put = (req_item.op == OP_PUT);
   assign fb_en    = (cfg.fb_base != 32'd0);
   assign load_ok  = (32'(req_item.font_index) < 32'(FONT_STORE_BYTES));
   assign rd_ok    = (32'(fidx_ff) < 32'(FONT_STORE_BYTES));
   assign move     = q_valid_ff && (!out_valid_ff || !rsp_stall);

   assign sts.glyph_req = code_put && fb_en && (req_item.char_code > SPACE_CODE);
   assign sts.q_free    = !q_valid_ff || move;

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   always_comb begin
      case (cfg.depth_mode)
         DEPTH_16: bpp = 3'd2;
         DEPTH_24: bpp = 3'd3;
         default:  bpp = 3'd4;
      endcase
   end

   always_comb begin
      gq_tab = '0;
      gx_tab = '0;
      for (int c = 0; c < 256; c++) begin
         if (req_item.char_code == 8'(c)) begin
            gq_tab = 8'((c * CELL_WIDTH) / GLYPH_SPAN);
            gx_tab = 8'(((c * CELL_WIDTH) % GLYPH_SPAN) / CELL_WIDTH);
         end
      end
   end

   always_comb begin
      col_in   = col_ff;
      line_in  = line_ff;
      col_inc  = {1'b0, col_ff} + 11'd1;
      line_inc = {1'b0, line_ff} + 11'd1;
      line_nx  = {1'b0, line_ff};
      if (cmd.accept && code_put && fb_en) begin
         if (req_item.char_code == NEWLINE_CODE) begin
            col_in  = '0;
            line_nx = line_inc;
         end else if (col_inc >= {1'b0, cfg.text_columns}) begin
            col_in  = '0;
            line_nx = line_inc;
         end else begin
            col_in  = col_inc[9:0];
         end
         if (line_nx >= {1'b0, cfg.text_rows}) begin
            line_in = '0;
         end else begin
            line_in = line_nx[9:0];
         end
      end
   end

   always_comb begin
      fidx_in = fidx_ff;
      addr_in = addr_ff;
      if (cmd.prep) begin
         fidx_in = FIDX_W'(32'(gq_ff) * 32'(FONT_ROW_STEP)) + FIDX_W'(gx_ff);
         addr_in = cfg.fb_base + (32'(lpx_ff) * 32'(cfg.line_pitch)) + 32'(xoff_ff);
      end else if (cmd.rd_issue) begin
         fidx_in = fidx_ff + FIDX_W'(IMG_PITCH);
         addr_in = addr_ff + 32'(cfg.line_pitch);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         line_ff      <= '0;
         q_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff  <= col_in;
         line_ff <= line_in;
         if (cmd.rd_issue) begin
            q_valid_ff <= 1'b1;
         end else if (move) begin
            q_valid_ff <= 1'b0;
         end
         if (move) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && code_put) begin
         gq_ff   <= gq_tab;
         gx_ff   <= gx_tab;
         lpx_ff  <= LPX_W'(32'(line_ff) * 32'(GLYPH_ROWS));
         xoff_ff <= {13'({3'b000, col_ff} * {10'd0, bpp}), 3'b000};
      end
      fidx_ff <= fidx_in;
      addr_ff <= addr_in;
      if (cmd.rd_issue) begin
         q_zero_ff <= !rd_ok;
         q_last_ff <= cmd.rd_last;
         q_addr_ff <= addr_ff;
      end
      if (move) begin
         out_item_ff.row_address <= q_addr_ff;
         out_item_ff.pixel_mask  <= q_zero_ff ? 8'd0 : mem_q_ff;
         out_item_ff.last_row    <= q_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && !code_put && load_ok) begin
         glyph_mem[AW'(req_item.font_index)] <= req_item.font_byte;
      end
      if (cmd.rd_issue) begin
         mem_q_ff <= glyph_mem[AW'(fidx_ff)];
      end
   end

endmodule

### sv/text_console_glyph_renderer.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer
// Text console renderer: loads font bytes, tracks a text cursor and emits one
// framebuffer row write per glyph row for each character above space, when fb_base is set.
//
//   channel   ports          direction   carries
//   request   req_*          in          font load or character item
//   response  rsp_*          out         row address, pixel mask, last row
//   config    csr_*          in/out      APB-style register access
//
// A font load or a non-drawing character does not hold off the next item. A drawn
// glyph holds off further items through an accept step, an address setup step,
// then one font store read per row through its single read port.
// Response stalls back up the read pipeline and pause the row reads.
// Synchronous reset clears cursor and control state; the glyph store is not
// cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer #(
   parameter int FONT_IMAGE_WIDTH = 128,
   parameter int FONT_STORE_BYTES = 8192,
   parameter int GLYPH_ROWS       = 15
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  tcgr_pkg::req_type                req_item,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output tcgr_pkg::rsp_type                rsp_item,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tcgr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import tcgr_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   tcgr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tcgr_ctrl #(
      .GLYPH_ROWS (GLYPH_ROWS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tcgr_dp #(
      .FONT_IMAGE_WIDTH (FONT_IMAGE_WIDTH),
      .FONT_STORE_BYTES (FONT_STORE_BYTES),
      .GLYPH_ROWS       (GLYPH_ROWS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_item  (req_item),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   a_glyph_blocks_input : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_item.op == OP_PUT && cfg.fb_base != 32'd0 &&
       req_item.char_code > SPACE_CODE) |=> req_stall)
      else $error("glyph accepted without blocking the next item");

   a_cmd_exclusive : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.prep, cmd.rd_issue}))
      else $error("accept, setup and row read overlap");

   a_read_needs_room : assert property (@(posedge clock) disable iff (reset)
      cmd.rd_issue |-> sts.q_free)
      else $error("row read issued into a full pipeline");

endmodule

### test/text_console_glyph_renderer_checker.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_checker
// Watches the request, response and register ports of the glyph renderer,
// keeps its own copy of the font, cursor and settings, predicts the row writes
// of every accepted character and compares each accepted row write with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_checker #(
   parameter int FONT_IMAGE_WIDTH = 128,
   parameter int FONT_STORE_BYTES = 8192,
   parameter int GLYPH_ROWS       = 15
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  tcgr_pkg::req_type                 req_item,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  tcgr_pkg::rsp_type                 rsp_item,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic                              csr_pready,
   input  logic [tcgr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output int                                mismatch_count,
   output int                                rows_due,
   output int                                rows_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import tcgr_pkg::*;

   localparam int REPORT_LIMIT = 40;

   cfg_type     render_cfg;
   int unsigned cursor_col;
   int unsigned cursor_row;
   logic [7:0]  font_bytes [FONT_STORE_BYTES];
   rsp_type     rows_pending [$];
   int          failures = 0;
   int          checked = 0;

   task automatic report_mismatch(input string what);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("%0t ns  row write mismatch: %s", $time, what);
      end
   endtask

   function automatic int unsigned bytes_per_pixel();
      case (render_cfg.depth_mode)
         DEPTH_16: return 2;
         DEPTH_24: return 3;
         default:  return 4;
      endcase
   endfunction

   function automatic void render_char(input logic [7:0] code);
      logic [31:0] span;
      logic [31:0] cell_pos;
      logic [31:0] glyph_x;
      logic [31:0] glyph_y;
      logic [31:0] x_offset;
      logic [31:0] font_pos;
      rsp_type     row;
      int          r;
      if (render_cfg.fb_base == '0) return;
      if (code == NEWLINE_CODE) begin
         cursor_row++;
         cursor_col = 0;
      end else begin
         if (code > SPACE_CODE) begin
            span = FONT_IMAGE_WIDTH - CELL_WIDTH;
            cell_pos = code * CELL_WIDTH;
            glyph_x = cell_pos % span;
            glyph_y = (cell_pos / span) * (GLYPH_ROWS + 1);
            x_offset = cursor_col * CELL_WIDTH * bytes_per_pixel();
            for (r = 0; r < GLYPH_ROWS; r++) begin
               font_pos = (glyph_y + r) * (FONT_IMAGE_WIDTH / 8) + glyph_x / 8;
               row.row_address = render_cfg.fb_base
                  + (cursor_row * GLYPH_ROWS + r) * render_cfg.line_pitch + x_offset;
               row.pixel_mask = (font_pos < FONT_STORE_BYTES) ? font_bytes[font_pos] : 8'h00;
               row.last_row = (r == GLYPH_ROWS - 1);
               rows_pending.push_back(row);
            end
         end
         cursor_col++;
         if (cursor_col >= render_cfg.text_columns) begin
            cursor_col = 0;
            cursor_row++;
         end
      end
      if (cursor_row >= render_cfg.text_rows) cursor_row = 0;
   endfunction

   task automatic check_row(input rsp_type got);
      rsp_type want;
      if (rows_pending.size() == 0) begin
         report_mismatch($sformatf("unexpected row, address %h mask %h last %b",
            got.row_address, got.pixel_mask, got.last_row));
      end else begin
         want = rows_pending.pop_front();
         checked++;
         if (got.row_address !== want.row_address) begin
            report_mismatch($sformatf("row_address %h, want %h",
               got.row_address, want.row_address));
         end
         if (got.pixel_mask !== want.pixel_mask) begin
            report_mismatch($sformatf("pixel_mask %h, want %h at address %h",
               got.pixel_mask, want.pixel_mask, want.row_address));
         end
         if (got.last_row !== want.last_row) begin
            report_mismatch($sformatf("last_row %b, want %b at address %h",
               got.last_row, want.last_row, want.row_address));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         render_cfg = '{fb_base: '0, line_pitch: '0, depth_mode: DEPTH_24,
                        text_columns: 10'd80, text_rows: 10'd32};
         cursor_col = 0;
         cursor_row = 0;
         rows_pending.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_FB_BASE:      render_cfg.fb_base = csr_pwdata;
               REG_LINE_PITCH:   render_cfg.line_pitch = csr_pwdata[15:0];
               REG_DEPTH_MODE:   render_cfg.depth_mode = csr_pwdata[1:0];
               REG_TEXT_COLUMNS: render_cfg.text_columns = csr_pwdata[9:0];
               REG_TEXT_ROWS:    render_cfg.text_rows = csr_pwdata[9:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) check_row(rsp_item);
         if (req_valid && !req_stall) begin
            if (req_item.op == OP_LOAD) begin
               if (req_item.font_index < FONT_STORE_BYTES) begin
                  font_bytes[req_item.font_index] = req_item.font_byte;
               end
            end else begin
               render_char(req_item.char_code);
            end
         end
      end
      mismatch_count <= failures;
      rows_due <= rows_pending.size();
      rows_checked <= checked;
   end

endmodule

### test/text_console_glyph_renderer_test.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_test
// Drives font loads and characters into the glyph renderer under a series of
// register settings: a directed opening over the extremes, then random
// phases of glyph loads, printable and control characters and stray loads,
// with random idling on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tcgr_pkg::*;

   localparam int FONT_IMAGE_WIDTH = 128;
   localparam int FONT_STORE_BYTES = 8192;
   localparam int GLYPH_ROWS       = 15;
   localparam int GLYPH_SPAN       = FONT_IMAGE_WIDTH - CELL_WIDTH;
   localparam int ITEM_TARGET      = 230;
   localparam int SETTLE_CYCLES    = GLYPH_ROWS + 4;
   localparam int HOLD_CYCLES      = 250;
   localparam int WATCHDOG_LIMIT   = 2000;

   localparam logic [1:0] DEPTH_32      = 2'd2;
   localparam logic [1:0] DEPTH_32_WIDE = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_item;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   int         mismatch_count;
   int         rows_due;
   int         rows_checked;
   int         items_sent = 0;
   int         loads_sent = 0;
   int         chars_sent = 0;
   int         settings_used = 0;
   bit         sender_quiet = 1'b0;
   bit         hold_results = 1'b0;
   bit         font_written [FONT_STORE_BYTES];
   logic [7:0] drawable_codes [$];

   text_console_glyph_renderer #(
      .FONT_IMAGE_WIDTH(FONT_IMAGE_WIDTH),
      .FONT_STORE_BYTES(FONT_STORE_BYTES),
      .GLYPH_ROWS(GLYPH_ROWS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   text_console_glyph_renderer_checker #(
      .FONT_IMAGE_WIDTH(FONT_IMAGE_WIDTH),
      .FONT_STORE_BYTES(FONT_STORE_BYTES),
      .GLYPH_ROWS(GLYPH_ROWS)
   ) checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .mismatch_count(mismatch_count),
      .rows_due(rows_due),
      .rows_checked(rows_checked)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int font_cell_index(input logic [7:0] code, input int r);
      int cell_pos;
      cell_pos = code * CELL_WIDTH;
      return ((cell_pos / GLYPH_SPAN) * (GLYPH_ROWS + 1) + r) * (FONT_IMAGE_WIDTH / 8)
         + (cell_pos % GLYPH_SPAN) / 8;
   endfunction

   function automatic logic [7:0] font_fill();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) return 8'h00;
      if (pick < 20) return 8'hFF;
      return 8'($urandom);
   endfunction

   function automatic int idle_gap();
      int pick;
      if (sender_quiet) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 4) return $urandom_range(10, 30);
      if (pick < 30) return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic logic [9:0] pick_count();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return 10'd0;
      if (pick < 20) return 10'd1023;
      if (pick < 50) return 10'($urandom_range(1, 4));
      return 10'($urandom_range(1, 1023));
   endfunction

   task automatic offer(input req_type item);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (req_stall);
      items_sent++;
      gap = idle_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_item <= req_type'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic load_font(input int idx, input logic [7:0] value);
      req_type item;
      item = req_type'($urandom);
      item.op = OP_LOAD;
      item.font_index = 13'(idx);
      item.font_byte = value;
      font_written[idx] = 1'b1;
      loads_sent++;
      offer(item);
   endtask

   task automatic put_char(input logic [7:0] code);
      req_type item;
      item = req_type'($urandom);
      item.op = OP_PUT;
      item.char_code = code;
      chars_sent++;
      offer(item);
   endtask

   // load whatever rows of the glyph are still missing, then place it
   task automatic put_glyph(input logic [7:0] code);
      int r;
      int idx;
      bit fresh;
      fresh = 1'b0;
      if (code > SPACE_CODE) begin
         for (r = 0; r < GLYPH_ROWS; r++) begin
            idx = font_cell_index(code, r);
            if (!font_written[idx]) begin
               load_font(idx, font_fill());
               fresh = 1'b1;
            end
         end
      end
      if (fresh) drawable_codes.push_back(code);
      put_char(code);
   endtask

   task automatic await_rows();
      @(negedge clock);
      req_valid <= 1'b0;
      while (rows_due != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_config(input logic [31:0] fb_base, input logic [15:0] line_pitch,
                               input logic [1:0] depth_mode, input logic [9:0] text_columns,
                               input logic [9:0] text_rows);
      await_rows();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(REG_FB_BASE, fb_base);
      write_reg(REG_LINE_PITCH, 32'(line_pitch));
      write_reg(REG_DEPTH_MODE, 32'(depth_mode));
      write_reg(REG_TEXT_COLUMNS, 32'(text_columns));
      write_reg(REG_TEXT_ROWS, 32'(text_rows));
      settings_used++;
   endtask

   initial begin : result_backpressure
      int stall_left;
      int mode_left;
      int pick;
      bit stall_quiet;
      stall_left = 0;
      mode_left = 0;
      stall_quiet = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            stall_quiet = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         if (hold_results) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_results = 1'b0;
         end else begin
            if (stall_left == 0 && !stall_quiet) begin
               pick = $urandom_range(0, 99);
               if (pick < 3) stall_left = $urandom_range(15, 40);
               else if (pick < 20) stall_left = $urandom_range(1, 3);
            end
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_psel && csr_penable)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("text_console_glyph_renderer_test: FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int r;
      int pick;
      int phase;
      logic [31:0] fb_pick;
      logic [15:0] pitch_pick;
      localparam logic [7:0] OPENING_CODES [8] =
         '{8'd33, 8'd255, 8'd0, 8'd32, 8'd10, 8'd31, 8'd127, 8'd33};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // rendering is off after reset: characters do nothing, loads still land
      put_char(8'd65);
      put_char(NEWLINE_CODE);
      for (r = 0; r < GLYPH_ROWS; r++) begin
         load_font(font_cell_index(8'd33, r),
            (r % 4 == 0) ? 8'h00 : (r % 4 == 1) ? 8'hFF : 8'h01 << (r % 8));
      end
      drawable_codes.push_back(8'd33);
      put_glyph(8'd255);
      load_font(FONT_STORE_BYTES - 1, 8'hFF);
      load_font(0, 8'h00);

      apply_config(32'h1000_0000, 16'd640, DEPTH_24, 10'd3, 10'd2);
      foreach (OPENING_CODES[i]) put_glyph(OPENING_CODES[i]);

      apply_config(32'hFFFF_FF00, 16'hFFFF, DEPTH_32_WIDE, 10'd1023, 10'd1023);
      put_glyph(8'd255);
      put_glyph(NEWLINE_CODE);
      put_glyph(8'd33);
      put_glyph(8'd255);

      apply_config(32'h0000_0001, 16'd0, DEPTH_16, 10'd0, 10'd0);
      put_glyph(8'd33);
      put_glyph(NEWLINE_CODE);
      put_glyph(8'd255);

      // park the cursor far out, then shrink the screen under it
      apply_config(32'h2000_0000, 16'd5120, DEPTH_32, 10'd1023, 10'd1023);
      repeat (3) put_glyph(NEWLINE_CODE);
      repeat (5) put_glyph(8'd33);
      apply_config(32'h2000_0000, 16'd5120, DEPTH_32, 10'd2, 10'd2);
      put_glyph(8'd255);
      put_glyph(8'd33);
      put_glyph(NEWLINE_CODE);

      phase = 0;
      while (items_sent < ITEM_TARGET || phase < 4) begin
         phase++;
         fb_pick = ($urandom_range(0, 3) == 0) ? (32'hFFFF_FF00 | $urandom_range(0, 255))
                                               : $urandom;
         pick = $urandom_range(0, 99);
         pitch_pick = (pick < 15) ? 16'd0 : (pick < 30) ? 16'hFFFF : 16'($urandom);
         apply_config((phase == 3) ? 32'h0 : fb_pick, pitch_pick, 2'($urandom_range(0, 3)),
                      pick_count(), pick_count());
         if (phase == 1) begin
            hold_results = 1'b1;
            sender_quiet = 1'b1;
            repeat (10) put_glyph(drawable_codes[$urandom_range(0, drawable_codes.size() - 1)]);
         end
         sender_quiet = ($urandom_range(0, 3) == 0);
         repeat (12) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               put_glyph(drawable_codes[$urandom_range(0, drawable_codes.size() - 1)]);
            end else if (pick < 58) begin
               put_glyph(8'($urandom_range(0, 32)));
            end else if (pick < 70) begin
               put_glyph(8'($urandom_range(0, 255)));
            end else if (pick < 80) begin
               load_font($urandom_range(0, FONT_STORE_BYTES - 1), 8'($urandom));
            end else if (pick < 90) begin
               load_font(font_cell_index(
                  drawable_codes[$urandom_range(0, drawable_codes.size() - 1)],
                  $urandom_range(0, GLYPH_ROWS - 1)), font_fill());
            end else begin
               await_rows();
            end
         end
      end

      await_rows();
      repeat (4 * GLYPH_ROWS) @(posedge clock);
      $display("covered %0d items (%0d font loads, %0d characters) over %0d register settings",
               items_sent, loads_sent, chars_sent, settings_used);
      $display("checked %0d glyph row writes; %0d glyphs in the font",
               rows_checked, drawable_codes.size());
      if (mismatch_count == 0 && rows_due == 0) begin
         $display("text_console_glyph_renderer_test: PASS");
      end else begin
         $display("text_console_glyph_renderer_test: FAIL");
      end
      $finish;
   end

endmodule
